// ----- src/ptna_pkg.sv -----
package ptna_pkg;

    localparam int MAX_NOTES   = 64;
    localparam int MAX_PITCHES = 4096;

    localparam int NOTE_W  = 16;
    localparam int COST_W  = 32;
    localparam int IDX_W   = $clog2(MAX_NOTES);
    localparam int PC_W    = $clog2(MAX_PITCHES + 1);
    localparam int OP_W    = 2;
    localparam int OUT_IDX_W = 6;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_PITCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic load;
        logic pitch;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ----- src/ptna_cell.sv -----
module ptna_cell
    import ptna_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [NOTE_W-1:0] value,
    input  logic              is_first,
    input  logic [COST_W-1:0] left_cost,
    input  logic              left_reached,
    input  logic              left_loaded,
    input  logic [COST_W-1:0] right_cost,
    input  logic              right_reached,
    input  logic              right_loaded,
    output logic [COST_W-1:0] cost,
    output logic              reached,
    output logic              loaded
);

    logic [NOTE_W-1:0] note_reg;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    logic              reached_reg;
    logic              loaded_reg;
    logic [NOTE_W-1:0] delta;
    logic [COST_W-1:0] prev;
    logic [COST_W:0]   sum;
    logic              upd;

    assign delta = (value > note_reg) ? (value - note_reg) : (note_reg - value);

    always_comb
    begin
        if (!reached_reg)
            prev = left_cost;
        else if (is_first)
            prev = cost_reg;
        else
            prev = (left_cost < cost_reg) ? left_cost : cost_reg;
        sum = {1'b0, prev} + {{(COST_W + 1 - NOTE_W){1'b0}}, delta};
        cost_next = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
    end

    assign upd = ctrl.pitch && loaded_reg && (reached_reg || left_reached);

    always_ff @(posedge clk)
    begin
        if (ctrl.load && !loaded_reg && left_loaded)
            note_reg <= value;
        if (ctrl.shift)
            cost_reg <= right_cost;
        else if (upd)
            cost_reg <= cost_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= 1'b0;
            loaded_reg  <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            reached_reg <= 1'b0;
            loaded_reg  <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            reached_reg <= right_reached;
            loaded_reg  <= right_loaded;
        end
        else
        begin
            if (upd)
                reached_reg <= 1'b1;
            if (ctrl.load && !loaded_reg && left_loaded)
                loaded_reg <= 1'b1;
        end
    end

    assign cost    = cost_reg;
    assign reached = reached_reg;
    assign loaded  = loaded_reg;

endmodule

// ----- src/pitch_to_note_alignment_cost.sv -----
// Load and pitch transactions are accepted one per cycle while the block is idle (s_tready high).
// All note costs update together in a row of cells, one cell per note.
// Finish: the row shifts toward cell 0 while the minimum is tracked, until cell 0 is
// no longer reached and loaded; the result is then registered, later while a previous
// result still waits. s_tready is low from finish until it is registered.
// Asynchronous active-low reset empties the note list and the pitch count.
module pitch_to_note_alignment_cost
    import ptna_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // op[1:0], value[17:2], zero[23:18]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // total_cost[31:0], note_index[37:32],
                                           // status[38], zero[39]
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;

    logic [1:0]        state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [COST_W-1:0] best_reg, best_next;
    logic              seen_reg, seen_next;
    logic              ov_reg, ov_next;
    logic [COST_W-1:0] oc_reg, oc_next;
    logic [OUT_IDX_W-1:0] oi_reg, oi_next;
    logic              os_reg, os_next;

    logic [OP_W-1:0]   op;
    logic [NOTE_W-1:0] value;
    logic              acc;
    cell_ctrl_t        ctrl;
    logic              live0;
    logic [IDX_W+OUT_IDX_W-1:0] idx_wide;

    logic [COST_W-1:0] cost_w    [MAX_NOTES];
    logic              reached_w [MAX_NOTES];
    logic              loaded_w  [MAX_NOTES];

    assign op    = s_tdata[OP_W-1:0];
    assign value = s_tdata[OP_W+NOTE_W-1:OP_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign acc   = s_tvalid && s_tready;
    assign live0 = reached_w[0] && loaded_w[0];
    assign idx_wide = {{OUT_IDX_W{1'b0}}, idx_reg};

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        seen_next  = seen_reg;
        ov_next    = ov_reg && !m_tready;
        oc_next    = oc_reg;
        oi_next    = oi_reg;
        os_next    = os_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (op)
                        OP_LOAD:
                            ctrl.load = (pc_reg == '0);
                        OP_PITCH:
                        begin
                            if (loaded_w[0] && pc_reg < PC_W'(MAX_PITCHES))
                            begin
                                ctrl.pitch = 1'b1;
                                pc_next    = pc_reg + 1'b1;
                            end
                        end
                        OP_FINISH:
                        begin
                            state_next = ST_SCAN;
                            k_next     = '0;
                            idx_next   = '0;
                            best_next  = '0;
                            seen_next  = 1'b0;
                        end
                        default:
                            ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (live0)
                begin
                    ctrl.shift = 1'b1;
                    k_next     = k_reg + 1'b1;
                    seen_next  = 1'b1;
                    if (!seen_reg || cost_w[0] < best_reg)
                    begin
                        best_next = cost_w[0];
                        idx_next  = k_reg;
                    end
                end
                else if (!ov_reg || m_tready)
                begin
                    ctrl.clear = 1'b1;
                    pc_next    = '0;
                    ov_next    = 1'b1;
                    oc_next    = best_reg;
                    oi_next    = idx_wide[OUT_IDX_W-1:0];
                    os_next    = !seen_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            ov_reg    <= 1'b0;
            seen_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ov_reg    <= ov_next;
            seen_reg  <= seen_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        best_reg <= best_next;
        oc_reg   <= oc_next;
        oi_reg   <= oi_next;
        os_reg   <= os_next;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_NOTES; g++)
        begin : g_cell
            logic [COST_W-1:0] lc, rc;
            logic              lr, ll, rr, rl;
            if (g == 0)
            begin : g_first
                assign lc = '0;
                assign lr = 1'b1;
                assign ll = 1'b1;
            end
            else
            begin : g_mid
                assign lc = cost_w[g-1];
                assign lr = reached_w[g-1];
                assign ll = loaded_w[g-1];
            end
            if (g == MAX_NOTES - 1)
            begin : g_last
                assign rc = '0;
                assign rr = 1'b0;
                assign rl = 1'b0;
            end
            else
            begin : g_inner
                assign rc = cost_w[g+1];
                assign rr = reached_w[g+1];
                assign rl = loaded_w[g+1];
            end
            ptna_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .value         (value),
                .is_first      (g == 0),
                .left_cost     (lc),
                .left_reached  (lr),
                .left_loaded   (ll),
                .right_cost    (rc),
                .right_reached (rr),
                .right_loaded  (rl),
                .cost          (cost_w[g]),
                .reached       (reached_w[g]),
                .loaded        (loaded_w[g])
            );
        end
    endgenerate

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, os_reg, oi_reg, oc_reg};

endmodule

// ----- src/ptna_chk.sv -----
module ptna_chk
    import ptna_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[38] |-> m_tdata[37:0] == '0)
        else $error("empty result carries nonzero fields");

    a_busy_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tdata[OP_W-1:0] == OP_FINISH))
        else $error("input stalled without a finish transaction");

endmodule

bind pitch_to_note_alignment_cost ptna_chk u_ptna_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/alignment_cost_checker.sv -----
module alignment_cost_checker
    import ptna_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // op[1:0], value[17:2], zero[23:18]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // total_cost[31:0], note_index[37:32],
                                           // status[38], zero[39]
    output int                   fail_count,
    output int                   pending,
    output int                   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COST_W-1:0]    total_cost;
        logic [OUT_IDX_W-1:0] note_index;
        logic                 status;
    } align_result_t;

    logic [NOTE_W-1:0] note_mem [MAX_NOTES];
    logic [COST_W-1:0] cost_mem [MAX_NOTES];
    int unsigned       notes_held;
    int unsigned       pitches_seen;
    align_result_t     expected_results [$];
    int                mismatches;
    int                checked;

    task automatic advance_cost_row(input logic [NOTE_W-1:0] pitch);
        int unsigned       top_cell;
        logic [COST_W-1:0] prev;
        logic [COST_W-1:0] delta;
        logic [COST_W:0]   sum;
        top_cell = (pitches_seen < notes_held - 1) ? pitches_seen : notes_held - 1;
        // walk downward so cell j still sees the old value of cell j-1
        for (int j = int'(top_cell); j >= 0; j--)
        begin
            if (pitch > note_mem[j])
                delta = COST_W'(pitch - note_mem[j]);
            else
                delta = COST_W'(note_mem[j] - pitch);
            if (j == 0)
                prev = (pitches_seen == 0) ? '0 : cost_mem[0];
            else if (j == int'(pitches_seen))
                prev = cost_mem[j-1];
            else
                prev = (cost_mem[j-1] < cost_mem[j]) ? cost_mem[j-1] : cost_mem[j];
            sum = {1'b0, prev} + {1'b0, delta};
            cost_mem[j] = sum[COST_W] ? '1 : sum[COST_W-1:0];
        end
        pitches_seen++;
    endtask

    function automatic align_result_t final_alignment();
        align_result_t r;
        int unsigned   last;
        r = '0;
        r.status = 1'b1;
        if (notes_held != 0 && pitches_seen != 0)
        begin
            last = (pitches_seen < notes_held) ? pitches_seen : notes_held;
            r.status = 1'b0;
            r.total_cost = cost_mem[0];
            for (int j = 1; j < int'(last); j++)
            begin
                if (cost_mem[j] < r.total_cost)
                begin
                    r.total_cost = cost_mem[j];
                    r.note_index = OUT_IDX_W'(j);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        align_result_t got;
        align_result_t want;
        if (!rst_n)
        begin
            notes_held = 0;
            pitches_seen = 0;
            expected_results.delete();
            mismatches = 0;
            checked = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                case (s_tdata[OP_W-1:0])
                    OP_LOAD:
                    begin
                        if (pitches_seen == 0 && notes_held < MAX_NOTES)
                        begin
                            note_mem[notes_held] = s_tdata[OP_W +: NOTE_W];
                            notes_held++;
                        end
                    end
                    OP_PITCH:
                    begin
                        if (notes_held != 0 && pitches_seen < MAX_PITCHES)
                            advance_cost_row(s_tdata[OP_W +: NOTE_W]);
                    end
                    OP_FINISH:
                    begin
                        expected_results.insert(expected_results.size(), final_alignment());
                        notes_held = 0;
                        pitches_seen = 0;
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.total_cost = m_tdata[COST_W-1:0];
                got.note_index = m_tdata[COST_W +: OUT_IDX_W];
                got.status     = m_tdata[COST_W + OUT_IDX_W];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result cost=%h idx=%0d st=%b",
                                 $realtime, got.total_cost, got.note_index, got.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.total_cost !== want.total_cost ||
                        got.note_index !== want.note_index ||
                        got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp cost=%h idx=%0d st=%b, ",
                                      "got cost=%h idx=%0d st=%b"},
                                     $realtime, want.total_cost, want.note_index, want.status,
                                     got.total_cost, got.note_index, got.status);
                    end
                end
            end
        end
        fail_count      <= mismatches;
        pending         <= expected_results.size();
        results_checked <= checked;
    end

endmodule

// ----- verif/pitch_to_note_alignment_cost_test.sv -----
module pitch_to_note_alignment_cost_test
    import ptna_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // op[1:0], value[17:2], zero[23:18]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;       // total_cost[31:0], note_index[37:32],
                                         // status[38], zero[39]
    int                   fail_count;
    int                   pending;
    int                   results_checked;
    bit                   steady = 1'b0;
    int                   alignments = 0;
    int                   frame_items = 0;
    int                   ignored_items = 0;
    int                   sent = 0;

    pitch_to_note_alignment_cost i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alignment_cost_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OP_W - NOTE_W){1'b0}}, val, op};
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic run_alignment(input int n_notes, input int n_pitches, input bit broken);
        logic [NOTE_W-1:0] notes [MAX_NOTES];
        logic [NOTE_W-1:0] val;
        int                span;
        span = (n_notes > MAX_NOTES) ? MAX_NOTES : n_notes;
        for (int j = 0; j < n_notes; j++)
        begin
            val = NOTE_W'($urandom());
            notes[j % MAX_NOTES] = val;
            send_item(OP_LOAD, val);
            frame_items++;
        end
        for (int i = 0; i < n_pitches; i++)
        begin
            // inject transactions the block must drop
            if (broken && i > 0 && $urandom_range(0, 5) == 0)
            begin
                send_item($urandom_range(0, 1) ? OP_UNUSED : OP_LOAD, NOTE_W'($urandom()));
                ignored_items++;
            end
            if ($urandom_range(0, 3) == 0)
                val = NOTE_W'($urandom());
            else
                val = notes[$urandom_range(0, span - 1)] + NOTE_W'($urandom_range(0, 64))
                      - NOTE_W'(32);
            send_item(OP_PITCH, val);
            frame_items++;
        end
        send_item(OP_FINISH, NOTE_W'($urandom()));
        frame_items++;
        alignments++;
    endtask

    initial
    begin : stimulus
        int n;
        int k;
        int r;
        int sel;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_FINISH, 16'h0000);
        send_item(OP_PITCH, 16'h1111);
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(OP_FINISH, 16'hFFFF);
        send_item(OP_LOAD, 16'h0000);
        send_item(OP_FINISH, 16'h0000);
        send_item(OP_LOAD, 16'h0000);
        send_item(OP_LOAD, 16'hFFFF);
        send_item(OP_LOAD, 16'h8000);
        send_item(OP_PITCH, 16'hFFFF);
        send_item(OP_LOAD, 16'h1234);
        send_item(OP_PITCH, 16'h0000);
        send_item(OP_PITCH, 16'h8000);
        send_item(OP_PITCH, 16'h7FFF);
        send_item(OP_FINISH, 16'h0000);
        send_item(OP_LOAD, 16'h0100);
        send_item(OP_LOAD, 16'h0200);
        send_item(OP_LOAD, 16'h0300);
        send_item(OP_LOAD, 16'h0400);
        send_item(OP_PITCH, 16'h0300);
        send_item(OP_PITCH, 16'h0400);
        send_item(OP_FINISH, 16'h0000);
        send_item(OP_LOAD, 16'h0050);
        send_item(OP_LOAD, 16'h0050);
        send_item(OP_PITCH, 16'h0050);
        send_item(OP_PITCH, 16'h0050);
        send_item(OP_FINISH, 16'h0000);
        wait_results();

        // fill the note store past capacity, follow the diagonal to the last note
        for (int j = 0; j < MAX_NOTES + 6; j++)
            send_item(OP_LOAD, (j < MAX_NOTES) ? NOTE_W'(j * 16) : NOTE_W'($urandom()));
        for (int i = 0; i < MAX_NOTES; i++)
            send_item(OP_PITCH, NOTE_W'(i * 16));
        send_item(OP_FINISH, 16'h0000);

        // run past the pitch limit with idling off on both sides
        steady = 1'b1;
        send_item(OP_LOAD, NOTE_W'($urandom()));
        send_item(OP_LOAD, NOTE_W'($urandom()));
        for (int i = 0; i < MAX_PITCHES + 4; i++)
            send_item(OP_PITCH, NOTE_W'($urandom()));
        send_item(OP_FINISH, 16'h0000);
        steady = 1'b0;
        wait_results();

        while (frame_items < 750)
        begin
            steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                send_item(OP_PITCH, NOTE_W'($urandom()));
                send_item(OP_FINISH, NOTE_W'($urandom()));
            end
            else if (r == 1)
                send_item(OP_UNUSED, NOTE_W'($urandom()));
            else if (r == 2)
            begin
                send_item(OP_LOAD, NOTE_W'($urandom()));
                send_item(OP_FINISH, NOTE_W'($urandom()));
            end
            else
            begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    n = $urandom_range(1, 6);
                else if (sel < 9)
                    n = $urandom_range(7, 20);
                else
                    n = $urandom_range(21, MAX_NOTES);
                if (n > 1 && $urandom_range(0, 2) == 0)
                    k = $urandom_range(1, n - 1);
                else
                    k = $urandom_range(1, 16);
                run_alignment(n, k, r < 5);
            end
            if ($urandom_range(0, 15) == 0)
                wait_results();
        end
        steady = 1'b0;

        wait_results();
        repeat (100) @(posedge clk);

        $display("Sent %0d transactions over %0d random alignments (%0d dropped on purpose),",
                 sent, alignments, ignored_items);
        $display("checked %0d results incl. empty finishes, full note store and pitch limit.",
                 results_checked);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
